@@ sv/cpbp_pkg.sv @@
// Shared types, codes, constants and helpers for the charger power budget policy.
package cpbp_pkg;

    // Field widths
    localparam int MA_W   = 12;
    localparam int MV_W   = 13;
    localparam int BMV_W  = 15;
    localparam int ADC_W  = 10;
    localparam int SHR_W  = 10;
    localparam int IDX_W  = 4;
    localparam int CFG_DW = 13;

    typedef logic [1:0]        led_t;
    typedef logic [1:0]        cmd_t;
    typedef logic [2:0]        tier_t;
    typedef logic [MA_W-1:0]   ma_t;
    typedef logic [BMV_W-1:0]  bmv_t;

    // LED modes
    localparam led_t LED_OFF   = 2'd0;
    localparam led_t LED_ON    = 2'd1;
    localparam led_t LED_BLINK = 2'd2;

    // Charger commands
    localparam cmd_t CMD_KEEP    = 2'd0;
    localparam cmd_t CMD_DISABLE = 2'd1;
    localparam cmd_t CMD_ENABLE  = 2'd2;

    // Actuator input limit tiers
    localparam tier_t TIER_HIZ = 3'd0;
    localparam tier_t TIER_100 = 3'd1;
    localparam tier_t TIER_150 = 3'd2;
    localparam tier_t TIER_500 = 3'd3;
    localparam tier_t TIER_900 = 3'd4;

    // Source states
    localparam logic [1:0] SRC_NORMAL = 2'd0;
    localparam logic [1:0] SRC_UNDERV = 2'd1;

    // Preferred source codes
    localparam logic [1:0] PREF_ADAPTER = 2'd1;
    localparam logic [1:0] PREF_USB     = 2'd2;

    // Battery and charger codes
    localparam logic [1:0] BATT_NORMAL       = 2'd0;
    localparam logic [2:0] SFLT_THERMAL      = 3'd2;
    localparam logic [2:0] SFLT_BATT         = 3'd7;
    localparam logic [2:0] SDEV_CHARGING     = 3'd2;
    localparam logic [1:0] ADEV_READY        = 2'd0;
    localparam logic [1:0] ADEV_CHARGING     = 2'd1;
    localparam logic [1:0] ADEV_FAULT        = 2'd3;
    localparam logic [3:0] AFLT_BATT_OV      = 4'd1;
    localparam logic [3:0] AFLT_DISCONNECTED = 4'd2;
    localparam logic [3:0] AFLT_THERMAL      = 4'd3;

    // USB limit codes with special LED patterns
    localparam logic [2:0] LIM_100  = 3'd1;
    localparam logic [2:0] LIM_150  = 3'd2;
    localparam logic [2:0] LIM_500  = 3'd3;
    localparam logic [2:0] LIM_800  = 3'd4;
    localparam logic [2:0] LIM_1500 = 3'd6;
    localparam logic [2:0] LIM_NONE = 3'd0;

    // Thresholds
    localparam bmv_t SYS_ABSENT_MV = 15'd500;
    localparam bmv_t ACT_ABSENT_MV = 15'd100;
    localparam ma_t  TIER_900_MA   = 12'd900;
    localparam ma_t  TIER_500_MA   = 12'd500;
    localparam ma_t  TIER_150_MA   = 12'd150;
    localparam ma_t  TIER_100_MA   = 12'd100;
    localparam ma_t  MAX_AVAIL_MA  = 12'd2500;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_SYS_ON     = 4'd0;
    localparam logic [IDX_W-1:0] REG_ACT_ON     = 4'd1;
    localparam logic [IDX_W-1:0] REG_SYS_LOAD   = 4'd2;
    localparam logic [IDX_W-1:0] REG_ACT_LOAD   = 4'd3;
    localparam logic [IDX_W-1:0] REG_PT_LOSS    = 4'd4;
    localparam logic [IDX_W-1:0] REG_SHARE      = 4'd5;
    localparam logic [IDX_W-1:0] REG_START_MV   = 4'd6;
    localparam logic [IDX_W-1:0] REG_LOW_BAT_MV = 4'd7;

    // Register reset values
    localparam logic             RST_SYS_ON     = 1'b1;
    localparam logic             RST_ACT_ON     = 1'b0;
    localparam ma_t              RST_SYS_LOAD   = 12'd750;
    localparam ma_t              RST_ACT_LOAD   = 12'd1500;
    localparam logic [SHR_W-1:0] RST_PT_LOSS    = 10'd150;
    localparam logic [SHR_W-1:0] RST_SHARE      = 10'd246;
    localparam logic [MV_W-1:0]  RST_START_MV   = 13'd4000;
    localparam logic [MV_W-1:0]  RST_LOW_BAT_MV = 13'd3200;

    typedef struct packed {
        logic             sys_on;
        logic             act_on;
        ma_t              sys_load;
        ma_t              act_load;
        logic [SHR_W-1:0] pt_loss;
        logic [SHR_W-1:0] share;
        logic [MV_W-1:0]  start_mv;
        logic [MV_W-1:0]  low_bat_mv;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       adapter_state;
        logic [1:0]       usb_state;
        logic [2:0]       adapter_limit;
        logic [2:0]       usb_limit;
        logic [1:0]       preferred_source;
        logic [ADC_W-1:0] sys_batt_adc;
        logic [ADC_W-1:0] act_batt_adc;
        logic [1:0]       sys_batt_state;
        logic [2:0]       sys_fault;
        logic [2:0]       sys_dev_state;
        logic [1:0]       act_dev_state;
        logic [3:0]       act_fault;
    } item_t;

    typedef struct packed {
        led_t  led_adapter;
        led_t  led_usb_low;
        led_t  led_usb_high;
        led_t  led_usb_full;
        led_t  led_sys_batt_stat;
        led_t  led_sys_batt_chrg;
        led_t  led_act_batt_stat;
        led_t  led_act_batt_chrg;
        cmd_t  sys_charge_cmd;
        cmd_t  act_charge_cmd;
        tier_t act_limit_tier;
        ma_t   remaining_ma;
    } result_t;

    // Limit code to mA
    function automatic ma_t limit_ma(input logic [2:0] code);
        ma_t r;
        unique case (code)
            3'd0:    r = 12'd0;
            3'd1:    r = 12'd100;
            3'd2:    r = 12'd150;
            3'd3:    r = 12'd500;
            3'd4:    r = 12'd800;
            3'd5:    r = 12'd900;
            3'd6:    r = 12'd1500;
            default: r = 12'd2500;
        endcase
        return r;
    endfunction

    // Subtract with floor at zero
    function automatic ma_t floor_sub(input ma_t a, input ma_t b);
        return (a > b) ? ma_t'(a - b) : '0;
    endfunction

    // ADC reading times 17, in mV
    function automatic bmv_t adc_to_mv(input logic [ADC_W-1:0] adc);
        return bmv_t'({1'b0, adc, 4'b0000}) + bmv_t'(adc);
    endfunction

endpackage

@@ sv/cpbp_cfg_regs.sv @@
// Configuration register file with its write port.
module cpbp_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [cpbp_pkg::IDX_W-1:0]    wr_index,
    input  logic [cpbp_pkg::CFG_DW-1:0]   wr_data,
    output cpbp_pkg::cfg_t                cfg
);

    cpbp_pkg::cfg_t cfg_reg;

    // Register writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sys_on     <= cpbp_pkg::RST_SYS_ON;
            cfg_reg.act_on     <= cpbp_pkg::RST_ACT_ON;
            cfg_reg.sys_load   <= cpbp_pkg::RST_SYS_LOAD;
            cfg_reg.act_load   <= cpbp_pkg::RST_ACT_LOAD;
            cfg_reg.pt_loss    <= cpbp_pkg::RST_PT_LOSS;
            cfg_reg.share      <= cpbp_pkg::RST_SHARE;
            cfg_reg.start_mv   <= cpbp_pkg::RST_START_MV;
            cfg_reg.low_bat_mv <= cpbp_pkg::RST_LOW_BAT_MV;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                cpbp_pkg::REG_SYS_ON:     cfg_reg.sys_on     <= wr_data[0];
                cpbp_pkg::REG_ACT_ON:     cfg_reg.act_on     <= wr_data[0];
                cpbp_pkg::REG_SYS_LOAD:   cfg_reg.sys_load   <= wr_data[cpbp_pkg::MA_W-1:0];
                cpbp_pkg::REG_ACT_LOAD:   cfg_reg.act_load   <= wr_data[cpbp_pkg::MA_W-1:0];
                cpbp_pkg::REG_PT_LOSS:    cfg_reg.pt_loss    <= wr_data[cpbp_pkg::SHR_W-1:0];
                cpbp_pkg::REG_SHARE:      cfg_reg.share      <= wr_data[cpbp_pkg::SHR_W-1:0];
                cpbp_pkg::REG_START_MV:   cfg_reg.start_mv   <= wr_data[cpbp_pkg::MV_W-1:0];
                cpbp_pkg::REG_LOW_BAT_MV: cfg_reg.low_bat_mv <= wr_data[cpbp_pkg::MV_W-1:0];
                default:                  cfg_reg            <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/cpbp_policy.sv @@
// Budget and LED policy for one status beat, pure combinational.
module cpbp_policy
(
    input  cpbp_pkg::item_t   item,
    input  cpbp_pkg::cfg_t    cfg,
    output cpbp_pkg::result_t result
);

    always_comb
    begin
        cpbp_pkg::ma_t  avail0;
        cpbp_pkg::ma_t  avail1;
        cpbp_pkg::ma_t  avail2;
        cpbp_pkg::ma_t  avail3;
        cpbp_pkg::ma_t  avail4;
        cpbp_pkg::ma_t  avail5;
        cpbp_pkg::ma_t  share;
        cpbp_pkg::ma_t  adp_ma;
        cpbp_pkg::ma_t  usb_ma;
        cpbp_pkg::bmv_t sys_mv;
        cpbp_pkg::bmv_t act_mv;
        cpbp_pkg::bmv_t start_mv;
        logic           adp_ok;
        logic           usb_ok;
        logic           sys_bad;

        result  = '0;
        share   = cpbp_pkg::ma_t'(cfg.share);
        sys_mv  = cpbp_pkg::adc_to_mv(item.sys_batt_adc);
        act_mv  = cpbp_pkg::adc_to_mv(item.act_batt_adc);
        start_mv = cpbp_pkg::bmv_t'(cfg.start_mv);

        // Adapter LED
        if (item.adapter_state == cpbp_pkg::SRC_NORMAL)
            result.led_adapter = cpbp_pkg::LED_ON;
        else if (item.adapter_state == cpbp_pkg::SRC_UNDERV)
            result.led_adapter = cpbp_pkg::LED_OFF;
        else
            result.led_adapter = cpbp_pkg::LED_BLINK;

        // USB LED bar
        result.led_usb_low  = cpbp_pkg::LED_OFF;
        result.led_usb_high = cpbp_pkg::LED_OFF;
        result.led_usb_full = cpbp_pkg::LED_BLINK;
        if (item.usb_state == cpbp_pkg::SRC_NORMAL)
        begin
            if (item.usb_limit == cpbp_pkg::LIM_100 || item.usb_limit == cpbp_pkg::LIM_150)
            begin
                result.led_usb_low  = cpbp_pkg::LED_ON;
                result.led_usb_full = cpbp_pkg::LED_OFF;
            end
            else if (item.usb_limit == cpbp_pkg::LIM_500)
            begin
                result.led_usb_low  = cpbp_pkg::LED_ON;
                result.led_usb_high = cpbp_pkg::LED_ON;
                result.led_usb_full = cpbp_pkg::LED_OFF;
            end
            else if (item.usb_limit >= cpbp_pkg::LIM_800 && item.usb_limit <= cpbp_pkg::LIM_1500)
            begin
                result.led_usb_low  = cpbp_pkg::LED_ON;
                result.led_usb_high = cpbp_pkg::LED_ON;
                result.led_usb_full = cpbp_pkg::LED_ON;
            end
        end
        else if (item.usb_state == cpbp_pkg::SRC_UNDERV)
        begin
            result.led_usb_full = cpbp_pkg::LED_OFF;
        end

        // Source selection in preference order
        adp_ma = cpbp_pkg::limit_ma(item.adapter_limit);
        usb_ma = cpbp_pkg::limit_ma(item.usb_limit);
        adp_ok = (item.adapter_state == cpbp_pkg::SRC_NORMAL) &&
                 (item.adapter_limit != cpbp_pkg::LIM_NONE);
        usb_ok = (item.usb_state == cpbp_pkg::SRC_NORMAL) &&
                 (item.usb_limit != cpbp_pkg::LIM_NONE);
        avail0 = '0;
        if (item.preferred_source == cpbp_pkg::PREF_ADAPTER)
            avail0 = adp_ok ? adp_ma : (usb_ok ? usb_ma : '0);
        else if (item.preferred_source == cpbp_pkg::PREF_USB)
            avail0 = usb_ok ? usb_ma : (adp_ok ? adp_ma : '0);

        // System load
        avail1 = cfg.sys_on ? cpbp_pkg::floor_sub(avail0, cfg.sys_load) : avail0;

        // System battery
        sys_bad = (item.sys_batt_state != cpbp_pkg::BATT_NORMAL) ||
                  (item.sys_fault == cpbp_pkg::SFLT_BATT) ||
                  (item.sys_fault == cpbp_pkg::SFLT_THERMAL);
        avail2 = avail1;
        result.sys_charge_cmd = cpbp_pkg::CMD_KEEP;
        if (sys_bad)
        begin
            result.sys_charge_cmd    = cpbp_pkg::CMD_DISABLE;
            result.led_sys_batt_chrg = cpbp_pkg::LED_OFF;
            result.led_sys_batt_stat = (sys_mv < cpbp_pkg::SYS_ABSENT_MV) ?
                                       cpbp_pkg::LED_OFF : cpbp_pkg::LED_BLINK;
        end
        else if (sys_mv > start_mv)
        begin
            result.led_sys_batt_stat = cpbp_pkg::LED_ON;
            if (item.sys_dev_state == cpbp_pkg::SDEV_CHARGING)
            begin
                if (avail1 > share)
                begin
                    avail2 = avail1 - share;
                    result.led_sys_batt_chrg = cpbp_pkg::LED_BLINK;
                end
                else
                begin
                    result.sys_charge_cmd    = cpbp_pkg::CMD_DISABLE;
                    result.led_sys_batt_chrg = cpbp_pkg::LED_OFF;
                end
            end
            else
            begin
                result.sys_charge_cmd    = cpbp_pkg::CMD_DISABLE;
                result.led_sys_batt_chrg = cpbp_pkg::LED_ON;
            end
        end
        else if (avail1 > share)
        begin
            avail2 = avail1 - share;
            result.sys_charge_cmd    = cpbp_pkg::CMD_ENABLE;
            result.led_sys_batt_chrg = cpbp_pkg::LED_BLINK;
            result.led_sys_batt_stat = cpbp_pkg::LED_ON;
        end
        else
        begin
            result.led_sys_batt_chrg = cpbp_pkg::LED_OFF;
            result.led_sys_batt_stat = (sys_mv < cpbp_pkg::bmv_t'(cfg.low_bat_mv)) ?
                                       cpbp_pkg::LED_BLINK : cpbp_pkg::LED_ON;
        end

        // Passthrough loss and actuator input tier
        avail3 = cpbp_pkg::floor_sub(avail2, cpbp_pkg::ma_t'(cfg.pt_loss));
        avail4 = avail3;
        priority if (avail3 > cpbp_pkg::TIER_900_MA)
            result.act_limit_tier = cpbp_pkg::TIER_900;
        else if (avail3 > cpbp_pkg::TIER_500_MA)
            result.act_limit_tier = cpbp_pkg::TIER_500;
        else if (avail3 > cpbp_pkg::TIER_150_MA)
            result.act_limit_tier = cpbp_pkg::TIER_150;
        else if (avail3 > cpbp_pkg::TIER_100_MA)
            result.act_limit_tier = cpbp_pkg::TIER_100;
        else
        begin
            result.act_limit_tier = cpbp_pkg::TIER_HIZ;
            avail4 = '0;
        end

        // Actuator load
        avail5 = cfg.act_on ? cpbp_pkg::floor_sub(avail4, cfg.act_load) : avail4;

        // Actuator battery
        result.act_charge_cmd = cpbp_pkg::CMD_KEEP;
        if (item.act_dev_state == cpbp_pkg::ADEV_FAULT)
        begin
            result.act_charge_cmd = cpbp_pkg::CMD_DISABLE;
            if (item.act_fault == cpbp_pkg::AFLT_BATT_OV ||
                item.act_fault == cpbp_pkg::AFLT_DISCONNECTED)
            begin
                result.led_act_batt_chrg = cpbp_pkg::LED_OFF;
                result.led_act_batt_stat = cpbp_pkg::LED_BLINK;
            end
            else if (item.act_fault == cpbp_pkg::AFLT_THERMAL)
            begin
                result.led_act_batt_chrg = cpbp_pkg::LED_OFF;
                result.led_act_batt_stat = (act_mv < cpbp_pkg::ACT_ABSENT_MV) ?
                                           cpbp_pkg::LED_OFF : cpbp_pkg::LED_BLINK;
            end
            else
            begin
                result.led_act_batt_chrg = cpbp_pkg::LED_BLINK;
                result.led_act_batt_stat = (act_mv < cpbp_pkg::ACT_ABSENT_MV) ?
                                           cpbp_pkg::LED_OFF : cpbp_pkg::LED_ON;
            end
        end
        else if (item.act_dev_state == cpbp_pkg::ADEV_READY)
        begin
            if (act_mv > cpbp_pkg::ACT_ABSENT_MV)
            begin
                result.led_act_batt_stat = cpbp_pkg::LED_ON;
                if (act_mv < start_mv && avail5 > share)
                begin
                    avail5 = avail5 - share;
                    result.act_charge_cmd    = cpbp_pkg::CMD_ENABLE;
                    result.led_act_batt_chrg = cpbp_pkg::LED_BLINK;
                end
                else
                begin
                    result.led_act_batt_chrg = cpbp_pkg::LED_OFF;
                end
            end
            else
            begin
                result.act_charge_cmd    = cpbp_pkg::CMD_DISABLE;
                result.led_act_batt_chrg = cpbp_pkg::LED_OFF;
                result.led_act_batt_stat = cpbp_pkg::LED_OFF;
            end
        end
        else if (item.act_dev_state == cpbp_pkg::ADEV_CHARGING)
        begin
            result.led_act_batt_stat = cpbp_pkg::LED_ON;
            if (avail5 > share)
            begin
                avail5 = avail5 - share;
                result.led_act_batt_chrg = cpbp_pkg::LED_BLINK;
            end
            else
            begin
                result.act_charge_cmd    = cpbp_pkg::CMD_DISABLE;
                result.led_act_batt_chrg = cpbp_pkg::LED_OFF;
            end
        end
        else
        begin
            result.act_charge_cmd    = cpbp_pkg::CMD_DISABLE;
            result.led_act_batt_chrg = cpbp_pkg::LED_OFF;
            result.led_act_batt_stat = cpbp_pkg::LED_ON;
        end

        result.remaining_ma = avail5;
    end

endmodule

@@ sv/charger_power_budget_policy_top.sv @@
// Top level: input register, policy logic, result register and configuration port.
//
//  channel   direction  handshake                 beat contents
//  item      in         item_valid / item_stall   status snapshot fields
//  result    out        result_valid / result_stall  LED modes, commands, tier, mA
//  cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item per cycle while item_stall is low; each beat is taken into the input register,
// then its policy logic result is loaded into the result register.
// Reset clears both stage valids and loads the register defaults; no clearing pass.
// A stalled result holds the result register; item_stall rises only when both
// stages are full and the result side is stalled. cfg_ready is always high.
module charger_power_budget_policy_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    // item channel
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [1:0]                    adapter_state,
    input  logic [1:0]                    usb_state,
    input  logic [2:0]                    adapter_limit,
    input  logic [2:0]                    usb_limit,
    input  logic [1:0]                    preferred_source,
    input  logic [cpbp_pkg::ADC_W-1:0]    sys_batt_adc,
    input  logic [cpbp_pkg::ADC_W-1:0]    act_batt_adc,
    input  logic [1:0]                    sys_batt_state,
    input  logic [2:0]                    sys_fault,
    input  logic [2:0]                    sys_dev_state,
    input  logic [1:0]                    act_dev_state,
    input  logic [3:0]                    act_fault,
    // result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [1:0]                    led_adapter,
    output logic [1:0]                    led_usb_low,
    output logic [1:0]                    led_usb_high,
    output logic [1:0]                    led_usb_full,
    output logic [1:0]                    led_sys_batt_stat,
    output logic [1:0]                    led_sys_batt_chrg,
    output logic [1:0]                    led_act_batt_stat,
    output logic [1:0]                    led_act_batt_chrg,
    output logic [1:0]                    sys_charge_cmd,
    output logic [1:0]                    act_charge_cmd,
    output logic [2:0]                    act_limit_tier,
    output logic [cpbp_pkg::MA_W-1:0]     remaining_ma,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cpbp_pkg::IDX_W-1:0]    cfg_index,
    input  logic [cpbp_pkg::CFG_DW-1:0]   cfg_data
);

    cpbp_pkg::cfg_t    cfg;
    cpbp_pkg::item_t   item_in;
    cpbp_pkg::item_t   item_reg;
    cpbp_pkg::result_t res_next;
    cpbp_pkg::result_t res_reg;
    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic              s2_load;
    logic              s1_load;

    // Configuration registers
    assign cfg_ready = 1'b1;

    cpbp_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Stage control: result register moves when empty or taken
    assign s2_load    = !s2_valid_reg || !result_stall;
    assign s1_load    = !s1_valid_reg || s2_load;
    assign item_stall = !s1_load;

    assign item_in.adapter_state    = adapter_state;
    assign item_in.usb_state        = usb_state;
    assign item_in.adapter_limit    = adapter_limit;
    assign item_in.usb_limit        = usb_limit;
    assign item_in.preferred_source = preferred_source;
    assign item_in.sys_batt_adc     = sys_batt_adc;
    assign item_in.act_batt_adc     = act_batt_adc;
    assign item_in.sys_batt_state   = sys_batt_state;
    assign item_in.sys_fault        = sys_fault;
    assign item_in.sys_dev_state    = sys_dev_state;
    assign item_in.act_dev_state    = act_dev_state;
    assign item_in.act_fault        = act_fault;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && item_valid)
            item_reg <= item_in;
    end

    // Policy logic
    cpbp_policy u_policy
    (
        .item   (item_reg),
        .cfg    (cfg),
        .result (res_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_load)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
            res_reg <= res_next;
    end

    assign result_valid      = s2_valid_reg;
    assign led_adapter       = res_reg.led_adapter;
    assign led_usb_low       = res_reg.led_usb_low;
    assign led_usb_high      = res_reg.led_usb_high;
    assign led_usb_full      = res_reg.led_usb_full;
    assign led_sys_batt_stat = res_reg.led_sys_batt_stat;
    assign led_sys_batt_chrg = res_reg.led_sys_batt_chrg;
    assign led_act_batt_stat = res_reg.led_act_batt_stat;
    assign led_act_batt_chrg = res_reg.led_act_batt_chrg;
    assign sys_charge_cmd    = res_reg.sys_charge_cmd;
    assign act_charge_cmd    = res_reg.act_charge_cmd;
    assign act_limit_tier    = res_reg.act_limit_tier;
    assign remaining_ma      = res_reg.remaining_ma;

endmodule

@@ sv/cpbp_checker.sv @@
// Port-level checker for the power budget policy, bound to the top level.
module cpbp_checker
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      result_valid,
    input  logic                      result_stall,
    input  logic [1:0]                led_usb_high,
    input  logic [1:0]                led_usb_full,
    input  logic [1:0]                led_sys_batt_chrg,
    input  logic [1:0]                sys_charge_cmd,
    input  logic [2:0]                act_limit_tier,
    input  logic [cpbp_pkg::MA_W-1:0] remaining_ma
);

    // A stalled result beat stays valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its budget fields
    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(remaining_ma) && $stable(act_limit_tier))
        else $error("stalled result beat changed");

    // High-Z tier leaves nothing for the actuator side
    a_hiz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && act_limit_tier == cpbp_pkg::TIER_HIZ |-> remaining_ma == '0)
        else $error("current left over with high-Z tier");

    // Enabling the system charger always shows the charging blink
    a_enable_led: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && sys_charge_cmd == cpbp_pkg::CMD_ENABLE |->
            led_sys_batt_chrg == cpbp_pkg::LED_BLINK)
        else $error("system charger enabled without charge LED blink");

    // Full USB LED lit only with the high LED lit
    a_usb_bar: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && led_usb_full == cpbp_pkg::LED_ON |-> led_usb_high == cpbp_pkg::LED_ON)
        else $error("usb LED bar out of order");

endmodule

bind charger_power_budget_policy_top cpbp_checker u_cpbp_checker (.*);
